// File: hdl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, constants and helper functions of the Modbus request framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

    // frame mode codes
    localparam logic [1:0] MODE_RTU   = 2'd0;
    localparam logic [1:0] MODE_ASCII = 2'd1;
    localparam logic [1:0] MODE_TCP   = 2'd2;

    // configuration register indexes
    localparam logic CFG_FRAME_MODE     = 1'b0;
    localparam logic CFG_LOW_BYTE_FIRST = 1'b1;

    // framing constants
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  CHR_COLON  = 8'h3A;
    localparam logic [7:0]  CHR_CR     = 8'h0D;
    localparam logic [7:0]  CHR_LF     = 8'h0A;
    localparam logic [7:0]  CHR_ZERO   = 8'h30;
    localparam logic [7:0]  CHR_A      = 8'h41;
    localparam logic [15:0] TID_RESET  = 16'h0001;

    // result list of one input beat
    localparam int unsigned MAX_BEATS = 7;

    typedef logic [2:0] t_cnt;

    typedef struct packed {
        logic [MAX_BEATS-1:0][7:0] bytes;
        t_cnt                      cnt;
        logic                      fend;
    } t_list;

    // running frame state
    typedef struct packed {
        logic [15:0] crc;
        logic [7:0]  sum;
        logic [15:0] tid;
        logic        in_frame;
    } t_state;

    // one crc-16 step over a byte, lsb first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // nibble to uppercase hex character
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = CHR_ZERO + {4'h0, nib};
        end else begin
            r = CHR_A + {4'h0, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage

// File: hdl/mrf_in_if.sv
// ----------------------------------------------------------------------------
// mrf_in_if
// Input channel: one frame byte per beat with its length and end flag.
// ----------------------------------------------------------------------------
interface mrf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] frame_length;
    logic       last_byte;

    modport source (output valid, data_byte, frame_length, last_byte, input ready);
    modport sink   (input valid, data_byte, frame_length, last_byte, output ready);
endinterface

// File: hdl/mrf_out_if.sv
// ----------------------------------------------------------------------------
// mrf_out_if
// Output channel: one byte or character of the framed stream per beat.
// ----------------------------------------------------------------------------
interface mrf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;

    modport source (output valid, out_byte, frame_end, run_last, input ready);
    modport sink   (input valid, out_byte, frame_end, run_last, output ready);
endinterface

// File: hdl/modbus_request_framer_top.sv
// The first result beat is registered and appears in the cycle after its input beat.
// One input beat per cycle while each byte yields one result beat and the output
// is not stalled; a byte of N beats (up to 7) holds the single output lane until all
// are out. ASCII bodies give 2 beats a byte; starts add up to 6 beats, ends up to 4.
// Reset (synchronous, active low): RTU mode, low byte first, CRC 0xFFFF,
// byte sum 0, transaction id 1, no frame open, output empty.
// ----------------------------------------------------------------------------
// modbus_request_framer_top
// Frames Modbus request bytes as RTU, ASCII or TCP streams.
// ----------------------------------------------------------------------------
module modbus_request_framer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrf_in_if.sink     i_in,
    mrf_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [1:0] i_cfg_data
);

    logic [1:0]      r_mode;
    logic            r_lbf;
    mrf_pkg::t_state r_state;
    mrf_pkg::t_state n_state;
    mrf_pkg::t_list  list;
    logic            free;
    logic            accept;

    assign i_in.ready = free;
    assign accept     = i_in.valid && free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mrf_pkg::MODE_RTU;
            r_lbf  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mrf_pkg::CFG_FRAME_MODE:     r_mode <= i_cfg_data;
                mrf_pkg::CFG_LOW_BYTE_FIRST: r_lbf  <= i_cfg_data[0];
                default:                     r_mode <= r_mode;
            endcase
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.crc      <= mrf_pkg::CRC_INIT;
            r_state.sum      <= 8'h00;
            r_state.tid      <= mrf_pkg::TID_RESET;
            r_state.in_frame <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    mrf_build u_build (
        .i_mode         (r_mode),
        .i_lbf          (r_lbf),
        .i_state        (r_state),
        .i_data_byte    (i_in.data_byte),
        .i_frame_length (i_in.frame_length),
        .i_last_byte    (i_in.last_byte),
        .o_list         (list),
        .o_state        (n_state)
    );

    mrf_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_list  (list),
        .o_free  (free),
        .o_out   (o_out)
    );

endmodule

// File: hdl/mrf_build.sv
// ----------------------------------------------------------------------------
// mrf_build
// Builds the list of output beats for one input byte and the next frame state.
// ----------------------------------------------------------------------------
module mrf_build (
    input  logic [1:0]      i_mode,
    input  logic            i_lbf,
    input  mrf_pkg::t_state i_state,
    input  logic [7:0]      i_data_byte,
    input  logic [7:0]      i_frame_length,
    input  logic            i_last_byte,
    output mrf_pkg::t_list  o_list,
    output mrf_pkg::t_state o_state
);

    logic [15:0]    crc_base;
    logic [15:0]    crc_new;
    logic [7:0]     sum_new;
    logic [7:0]     lrc;
    mrf_pkg::t_cnt  k;
    mrf_pkg::t_list lst;

    // checksums restart on the first byte of a frame
    assign crc_base = i_state.in_frame ? i_state.crc : mrf_pkg::CRC_INIT;
    assign crc_new  = mrf_pkg::crc_fold(crc_base, i_data_byte);
    assign sum_new  = (i_state.in_frame ? i_state.sum : 8'h00) + i_data_byte;
    assign lrc      = 8'h00 - sum_new;

    // append prefix, body and trailer beats in order
    always_comb begin
        lst = '0;
        k   = '0;
        if (!i_state.in_frame) begin
            if (i_mode == mrf_pkg::MODE_ASCII) begin
                lst.bytes[k] = mrf_pkg::CHR_COLON;
                k = k + 3'd1;
            end else if (i_mode == mrf_pkg::MODE_TCP) begin
                lst.bytes[k] = i_lbf ? i_state.tid[7:0] : i_state.tid[15:8];
                k = k + 3'd1;
                lst.bytes[k] = i_lbf ? i_state.tid[15:8] : i_state.tid[7:0];
                k = k + 3'd1;
                lst.bytes[k] = 8'h00;
                k = k + 3'd1;
                lst.bytes[k] = 8'h00;
                k = k + 3'd1;
                lst.bytes[k] = i_lbf ? i_frame_length : 8'h00;
                k = k + 3'd1;
                lst.bytes[k] = i_lbf ? 8'h00 : i_frame_length;
                k = k + 3'd1;
            end
        end
        if (i_mode == mrf_pkg::MODE_ASCII) begin
            lst.bytes[k] = mrf_pkg::hex_char(i_data_byte[7:4]);
            k = k + 3'd1;
            lst.bytes[k] = mrf_pkg::hex_char(i_data_byte[3:0]);
            k = k + 3'd1;
        end else begin
            lst.bytes[k] = i_data_byte;
            k = k + 3'd1;
        end
        if (i_last_byte) begin
            if (i_mode == mrf_pkg::MODE_RTU) begin
                lst.bytes[k] = i_lbf ? crc_new[7:0] : crc_new[15:8];
                k = k + 3'd1;
                lst.bytes[k] = i_lbf ? crc_new[15:8] : crc_new[7:0];
                k = k + 3'd1;
            end else if (i_mode == mrf_pkg::MODE_ASCII) begin
                lst.bytes[k] = mrf_pkg::hex_char(lrc[7:4]);
                k = k + 3'd1;
                lst.bytes[k] = mrf_pkg::hex_char(lrc[3:0]);
                k = k + 3'd1;
                lst.bytes[k] = mrf_pkg::CHR_CR;
                k = k + 3'd1;
                lst.bytes[k] = mrf_pkg::CHR_LF;
                k = k + 3'd1;
            end
        end
        lst.cnt  = k;
        lst.fend = i_last_byte;
    end

    assign o_list = lst;

    // next frame state
    always_comb begin
        o_state.tid = i_state.tid;
        if (!i_state.in_frame && i_mode == mrf_pkg::MODE_TCP) begin
            o_state.tid = i_state.tid + 16'd1;
        end
        if (i_last_byte) begin
            o_state.crc      = mrf_pkg::CRC_INIT;
            o_state.sum      = 8'h00;
            o_state.in_frame = 1'b0;
        end else begin
            o_state.crc      = crc_new;
            o_state.sum      = sum_new;
            o_state.in_frame = 1'b1;
        end
    end

endmodule

// File: hdl/mrf_emit.sv
// ----------------------------------------------------------------------------
// mrf_emit
// Result register: holds the beat list of one input byte and shifts it out.
// ----------------------------------------------------------------------------
module mrf_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  mrf_pkg::t_list i_list,
    output logic           o_free,
    mrf_out_if.source      o_out
);

    logic [mrf_pkg::MAX_BEATS-1:0][7:0] r_bytes, n_bytes;
    mrf_pkg::t_cnt                      r_left,  n_left;
    logic                               r_fend,  n_fend;
    logic                               beat;

    assign beat   = o_out.valid && o_out.ready;
    // free when empty or the last pending beat goes out now
    assign o_free = (r_left == 3'd0) || (r_left == 3'd1 && o_out.ready);

    // shift on each beat, reload on a new list
    always_comb begin
        n_bytes = r_bytes;
        n_left  = r_left;
        n_fend  = r_fend;
        if (i_load) begin
            n_bytes = i_list.bytes;
            n_left  = i_list.cnt;
            n_fend  = i_list.fend;
        end else if (beat) begin
            n_bytes = {8'h00, r_bytes[mrf_pkg::MAX_BEATS-1:1]};
            n_left  = r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_fend  <= n_fend;
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    assign o_out.valid     = (r_left != 3'd0);
    assign o_out.out_byte  = r_bytes[0];
    assign o_out.run_last  = (r_left == 3'd1);
    assign o_out.frame_end = (r_left == 3'd1) && r_fend;

endmodule

// File: hdl/mrf_checker.sv
// ----------------------------------------------------------------------------
// mrf_checker
// Port-level checks on the framer output stream, bound to the top level.
// ----------------------------------------------------------------------------
module mrf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_frame_end,
    input logic       i_run_last
);

    // output empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // frame end only on the last beat of a byte
    a_fend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_end |-> i_run_last)
        else $error("frame end not on last beat");

    // no input taken while more beats of the current byte remain
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_run_last |-> !i_in_ready)
        else $error("input taken with beats pending");

    // stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("stalled beat changed");

endmodule

bind modbus_request_framer_top mrf_checker u_mrf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_frame_end (o_out.frame_end),
    .i_run_last  (o_out.run_last)
);
